FILE: src/rational_arithmetic_unit_assert.svh
// ----------------------------------------------------------------------------
// Rational arithmetic unit assertion macros
// Concurrent assertion wrappers that disappear in synthesis builds.
// ----------------------------------------------------------------------------
`ifndef RATIONAL_ARITHMETIC_UNIT_ASSERT_SVH
`define RATIONAL_ARITHMETIC_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication.
`define RAU_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rau assertion failed");
// Next-cycle implication.
`define RAU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rau assertion failed");
`else
`define RAU_ASSERT_NOW(lbl, clk, rst_n, ante, cons)
`define RAU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

FILE: src/rau_pkg.sv
// ----------------------------------------------------------------------------
// Rational arithmetic unit package
// Request and result payloads, queue entry type and operation codes.
// ----------------------------------------------------------------------------
package rau_pkg;

  localparam logic [2:0] MODE_ADD = 3'd0;
  localparam logic [2:0] MODE_SUB = 3'd1;
  localparam logic [2:0] MODE_MUL = 3'd2;
  localparam logic [2:0] MODE_DIV = 3'd3;

  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_ZERO_DEN = 2'd1;
  localparam logic [1:0] STATUS_DIV_ZERO = 2'd2;

  typedef struct packed {
    logic [2:0]         mode;
    logic signed [31:0] a_num;
    logic [30:0]        a_den;
    logic signed [31:0] b_num;
    logic [30:0]        b_den;
  } rau_in_t;

  typedef struct packed {
    logic signed [63:0] res_num;
    logic [62:0]        res_den;
    logic               less;
    logic               equal;
    logic [1:0]         status;
  } rau_out_t;

  // Classified request as it travels from the front end to the back end.
  typedef struct packed {
    logic [2:0]         mode;
    logic signed [31:0] an;
    logic signed [31:0] ad;
    logic signed [31:0] bn;
    logic signed [31:0] bd;
    logic               zero_den;
  } rau_entry_t;

endpackage

FILE: src/rau_front.sv
// ----------------------------------------------------------------------------
// Rational arithmetic unit front end
// Accepts requests, trims operands to the configured width and flags zero
// denominators before handing the request to the queue.
// ----------------------------------------------------------------------------
module rau_front #(
  parameter int OPERAND_WIDTH = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  rau_pkg::rau_in_t    in_data,
  input  logic                q_full,
  output logic                q_push,
  output rau_pkg::rau_entry_t q_entry
);

  localparam int NUM_SHIFT = 32 - OPERAND_WIDTH;
  localparam logic [30:0] DEN_MASK = 31'((64'd1 << (OPERAND_WIDTH - 1)) - 64'd1);

  logic                hold_valid_r, hold_valid_nxt;
  rau_pkg::rau_entry_t hold_r;
  rau_pkg::rau_entry_t cls;
  logic                accept;
  logic signed [31:0]  an_shl, bn_shl;
  logic [30:0]         ad_m, bd_m;

  always_comb begin
    an_shl = in_data.a_num <<< NUM_SHIFT;
    bn_shl = in_data.b_num <<< NUM_SHIFT;
    ad_m   = in_data.a_den & DEN_MASK;
    bd_m   = in_data.b_den & DEN_MASK;
    cls.mode     = in_data.mode;
    cls.an       = an_shl >>> NUM_SHIFT;
    cls.bn       = bn_shl >>> NUM_SHIFT;
    cls.ad       = $signed({1'b0, ad_m});
    cls.bd       = $signed({1'b0, bd_m});
    cls.zero_den = (ad_m == '0) || (bd_m == '0);
  end

  assign in_stall       = hold_valid_r && q_full;
  assign accept         = in_valid && !in_stall;
  assign q_push         = hold_valid_r && !q_full;
  assign q_entry        = hold_r;
  assign hold_valid_nxt = accept || (hold_valid_r && q_full);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_valid_r <= 1'b0;
    end else begin
      hold_valid_r <= hold_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      hold_r <= cls;
    end
  end

endmodule

FILE: src/rau_queue.sv
// ----------------------------------------------------------------------------
// Rational arithmetic unit request queue
// Two-entry queue that decouples the front end from the back end.
// ----------------------------------------------------------------------------
module rau_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  rau_pkg::rau_entry_t push_entry,
  output logic                full,
  input  logic                pop,
  output logic                q_valid,
  output rau_pkg::rau_entry_t pop_entry
);

  rau_pkg::rau_entry_t mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;

  assign full      = (count_r == 2'd2);
  assign q_valid   = (count_r != 2'd0);
  assign pop_entry = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule

FILE: src/rau_back.sv
// ----------------------------------------------------------------------------
// Rational arithmetic unit back end
// Sequencer with one shared multiplier, a binary gcd and two bit-serial
// dividers that reduce the result to lowest terms.
// ----------------------------------------------------------------------------
`include "rational_arithmetic_unit_assert.svh"

module rau_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_valid,
  input  rau_pkg::rau_entry_t q_entry,
  output logic                q_pop,
  output logic                out_valid,
  input  logic                out_stall,
  output rau_pkg::rau_out_t   out_data
);

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_MUL0  = 4'd1;
  localparam logic [3:0] ST_MUL1  = 4'd2;
  localparam logic [3:0] ST_MUL2  = 4'd3;
  localparam logic [3:0] ST_PREP  = 4'd4;
  localparam logic [3:0] ST_NORM  = 4'd5;
  localparam logic [3:0] ST_GCD   = 4'd6;
  localparam logic [3:0] ST_SHIFT = 4'd7;
  localparam logic [3:0] ST_DIV   = 4'd8;
  localparam logic [3:0] ST_DONE  = 4'd9;
  localparam logic [3:0] ST_MUL3  = 4'd10;

  logic [3:0]          state_r, state_nxt;
  rau_pkg::rau_entry_t ent_r;
  logic signed [63:0]  p0_r, p1_r, p2_r, p3_r, prod;
  logic signed [31:0]  op_a, op_b;
  logic signed [63:0]  num_r, den_r;
  logic                less_r, equal_r, reduce_r, neg_r;
  logic [1:0]          status_r;
  logic [63:0]         u_r, v_r, g_r;
  logic [5:0]          k_r, cnt_r;
  logic [63:0]         qn_r, qd_r, rn_r, rd_r;
  logic [63:0]         rn_sh, rd_sh;
  logic                out_valid_r, out_valid_nxt;
  rau_pkg::rau_out_t   out_r;
  logic                load_out;
  logic                div_zero;

  assign q_pop     = (state_r == ST_IDLE) && q_valid;
  assign load_out  = (state_r == ST_DONE) && (!out_valid_r || !out_stall);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign div_zero  = (ent_r.mode == rau_pkg::MODE_DIV) && (ent_r.bn == '0);

  always_comb begin
    case (state_r)
      ST_MUL0: begin
        op_a = ent_r.an;
        op_b = ent_r.bd;
      end
      ST_MUL1: begin
        op_a = ent_r.bn;
        op_b = ent_r.ad;
      end
      ST_MUL3: begin
        op_a = ent_r.an;
        op_b = ent_r.bn;
      end
      default: begin
        op_a = ent_r.ad;
        op_b = ent_r.bd;
      end
    endcase
    prod  = op_a * op_b;
    rn_sh = {rn_r[62:0], qn_r[63]};
    rd_sh = {rd_r[62:0], qd_r[63]};
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          state_nxt = q_entry.zero_den ? ST_DONE : ST_MUL0;
        end
      end
      ST_MUL0:  state_nxt = ST_MUL1;
      ST_MUL1:  state_nxt = ST_MUL2;
      ST_MUL2:  state_nxt = ST_MUL3;
      ST_MUL3:  state_nxt = ST_PREP;
      ST_PREP: begin
        if ((ent_r.mode[2] == 1'b0) && !div_zero) begin
          state_nxt = ST_NORM;
        end else begin
          state_nxt = ST_DONE;
        end
      end
      ST_NORM:  state_nxt = ST_GCD;
      ST_GCD: begin
        if (u_r == '0) begin
          state_nxt = ST_SHIFT;
        end
      end
      ST_SHIFT: state_nxt = ST_DIV;
      ST_DIV: begin
        if (cnt_r == 6'd63) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (load_out) begin
          state_nxt = ST_IDLE;
        end
      end
      default:  state_nxt = ST_IDLE;
    endcase
    out_valid_nxt = load_out || (out_valid_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        ent_r    <= q_entry;
        less_r   <= 1'b0;
        equal_r  <= 1'b0;
        reduce_r <= 1'b0;
        status_r <= rau_pkg::STATUS_ZERO_DEN;
      end
      ST_MUL0: p0_r <= prod;
      ST_MUL1: p1_r <= prod;
      ST_MUL2: p2_r <= prod;
      ST_MUL3: p3_r <= prod;
      ST_PREP: begin
        less_r  <= p0_r < p1_r;
        equal_r <= p0_r == p1_r;
        case (ent_r.mode)
          rau_pkg::MODE_ADD: begin
            num_r <= p0_r + p1_r;
            den_r <= p2_r;
          end
          rau_pkg::MODE_SUB: begin
            num_r <= p0_r - p1_r;
            den_r <= p2_r;
          end
          rau_pkg::MODE_MUL: begin
            num_r <= p3_r;
            den_r <= p2_r;
          end
          rau_pkg::MODE_DIV: begin
            num_r <= p0_r;
            den_r <= p1_r;
          end
          default: begin
            num_r <= '0;
            den_r <= p2_r;
          end
        endcase
        if (div_zero) begin
          status_r <= rau_pkg::STATUS_DIV_ZERO;
          reduce_r <= 1'b0;
        end else begin
          status_r <= rau_pkg::STATUS_OK;
          reduce_r <= (ent_r.mode[2] == 1'b0);
        end
      end
      ST_NORM: begin
        // Work on magnitudes; the sign is put back after the division.
        neg_r <= num_r[63] ^ den_r[63];
        u_r   <= num_r[63] ? 64'(-num_r) : 64'(num_r);
        v_r   <= den_r[63] ? 64'(-den_r) : 64'(den_r);
        qn_r  <= num_r[63] ? 64'(-num_r) : 64'(num_r);
        qd_r  <= den_r[63] ? 64'(-den_r) : 64'(den_r);
        k_r   <= '0;
      end
      ST_GCD: begin
        if (u_r != '0) begin
          if (!u_r[0] && !v_r[0]) begin
            u_r <= u_r >> 1;
            v_r <= v_r >> 1;
            k_r <= k_r + 6'd1;
          end else if (!u_r[0]) begin
            u_r <= u_r >> 1;
          end else if (!v_r[0]) begin
            v_r <= v_r >> 1;
          end else if (u_r >= v_r) begin
            u_r <= (u_r - v_r) >> 1;
          end else begin
            v_r <= (v_r - u_r) >> 1;
          end
        end
      end
      ST_SHIFT: begin
        g_r   <= v_r << k_r;
        cnt_r <= '0;
        rn_r  <= '0;
        rd_r  <= '0;
      end
      ST_DIV: begin
        // Restoring division of both magnitudes by the gcd, one bit a cycle.
        cnt_r <= cnt_r + 6'd1;
        if (rn_sh >= g_r) begin
          rn_r <= rn_sh - g_r;
          qn_r <= {qn_r[62:0], 1'b1};
        end else begin
          rn_r <= rn_sh;
          qn_r <= {qn_r[62:0], 1'b0};
        end
        if (rd_sh >= g_r) begin
          rd_r <= rd_sh - g_r;
          qd_r <= {qd_r[62:0], 1'b1};
        end else begin
          rd_r <= rd_sh;
          qd_r <= {qd_r[62:0], 1'b0};
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_r.res_num <= reduce_r ? (neg_r ? $signed(-qn_r) : $signed(qn_r)) : '0;
      out_r.res_den <= reduce_r ? qd_r[62:0] : '0;
      out_r.less    <= less_r;
      out_r.equal   <= equal_r;
      out_r.status  <= status_r;
    end
  end

  `RAU_ASSERT_NOW(a_pop_has_entry, clk, rst_n, q_pop, q_valid)
  `RAU_ASSERT_NOW(a_gcd_v_nonzero, clk, rst_n, state_r == ST_GCD, v_r != '0)
  `RAU_ASSERT_NOW(a_div_g_nonzero, clk, rst_n, state_r == ST_DIV, g_r != '0)
  `RAU_ASSERT_NEXT(a_done_to_idle, clk, rst_n, load_out, state_r == ST_IDLE)

endmodule

FILE: src/rational_arithmetic_unit.sv
// ----------------------------------------------------------------------------
// Rational arithmetic unit
// Adds, subtracts, multiplies, divides or compares two fractions and gives
// the result in lowest terms with a positive denominator.
// ----------------------------------------------------------------------------
// Channel  Direction  Handshake              Payload
// in       input      in_valid / in_stall    rau_in_t
// out      output     out_valid / out_stall  rau_out_t
//
// A reducing request forms four products in turn on the shared multiplier,
// then runs the binary gcd and the two bit-serial dividers.
// A compare or a division by zero skips the gcd and the division; a zero
// denominator also skips the multiplier and goes straight to the result.
// Reset is synchronous and active low; there is no clearing pass.
// A two-entry queue lets requests be taken while the back end works or the
// result waits under out_stall.
// ----------------------------------------------------------------------------
module rational_arithmetic_unit #(
  parameter int OPERAND_WIDTH = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  rau_pkg::rau_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output rau_pkg::rau_out_t out_data
);

  logic                q_full, q_push, q_pop, q_valid;
  rau_pkg::rau_entry_t push_entry, pop_entry;

  rau_front #(
    .OPERAND_WIDTH(OPERAND_WIDTH)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_entry  (push_entry)
  );

  rau_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (push_entry),
    .full       (q_full),
    .pop        (q_pop),
    .q_valid    (q_valid),
    .pop_entry  (pop_entry)
  );

  rau_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_entry   (pop_entry),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

FILE: tb/sv/rational_arithmetic_unit_tb.sv
// ----------------------------------------------------------------------------
// Rational arithmetic unit testbench
// Sends fraction requests with random idling on both channels, predicts each
// reduced result and the compare flags, and checks them in order.
// ----------------------------------------------------------------------------
module rational_arithmetic_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0] MODE_CMP = 3'd4;
  localparam int CYCLE_LIMIT = 1500000;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  rau_pkg::rau_in_t  in_data;
  logic              out_valid;
  logic              out_stall;
  rau_pkg::rau_out_t out_data;

  rau_pkg::rau_out_t result_queue[$];
  int       mismatch_count = 0;
  int       send_idle_pct  = 0;
  int       recv_stall_pct = 0;
  int       cycle_count    = 0;

  rational_arithmetic_unit u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic longint unsigned gcd_of(longint unsigned m, longint unsigned n);
    longint unsigned c;
    while (m != 0) begin
      c = n % m;
      n = m;
      m = c;
    end
    return n;
  endfunction

  // Exact fraction arithmetic at 64 bits; every product fits.
  function automatic rau_pkg::rau_out_t fraction_result(rau_pkg::rau_in_t req);
    rau_pkg::rau_out_t r;
    longint            an, ad, bn, bd, lhs, rhs, num, den;
    longint unsigned   g, mag;
    r = '0;
    an = longint'(req.a_num);
    bn = longint'(req.b_num);
    ad = longint'({1'b0, req.a_den});
    bd = longint'({1'b0, req.b_den});
    num = 0;
    den = 0;
    if (ad == 0 || bd == 0) begin
      r.status = rau_pkg::STATUS_ZERO_DEN;
      return r;
    end
    lhs = an * bd;
    rhs = bn * ad;
    r.less  = lhs < rhs;
    r.equal = lhs == rhs;
    case (req.mode)
      rau_pkg::MODE_ADD: begin num = lhs + rhs; den = ad * bd; end
      rau_pkg::MODE_SUB: begin num = lhs - rhs; den = ad * bd; end
      rau_pkg::MODE_MUL: begin num = an * bn;   den = ad * bd; end
      rau_pkg::MODE_DIV: begin
        if (bn == 0) begin
          r.status = rau_pkg::STATUS_DIV_ZERO;
        end else begin
          num = lhs;
          den = ad * bn;
          if (den < 0) begin num = -num; den = -den; end
        end
      end
      default: ;
    endcase
    if (req.mode <= rau_pkg::MODE_DIV && r.status == rau_pkg::STATUS_OK) begin
      mag = num < 0 ? -num : num;
      g = gcd_of(mag, den);
      if (g != 0) begin
        num = num / longint'(g);
        den = den / longint'(g);
      end
      r.res_num = num;
      r.res_den = den[62:0];
    end
    return r;
  endfunction

  task automatic report_mismatch(string field, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d", field, got, want);
    mismatch_count++;
  endtask

  // Called at a falling edge; leaves in_valid high so requests can follow
  // without a gap.
  task automatic send_request(rau_pkg::rau_in_t req);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    result_queue.push_back(fraction_result(req));
    @(negedge clk);
  endtask

  // Receiver stall, changed on the falling edge.
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout");
      $display("== FAIL ==");
      $finish;
    end
    if (rst_n && out_valid && !out_stall) begin
      if (result_queue.size() == 0) begin
        report_mismatch("unexpected result", 0, 0);
      end else begin
        rau_pkg::rau_out_t want;
        want = result_queue.pop_front();
        if (out_data.res_num !== want.res_num)
          report_mismatch("res_num", out_data.res_num, want.res_num);
        if (out_data.res_den !== want.res_den)
          report_mismatch("res_den", out_data.res_den, want.res_den);
        if (out_data.less !== want.less)
          report_mismatch("less", out_data.less, want.less);
        if (out_data.equal !== want.equal)
          report_mismatch("equal", out_data.equal, want.equal);
        if (out_data.status !== want.status)
          report_mismatch("status", out_data.status, want.status);
      end
    end
  end

  function automatic logic [31:0] rand_num();
    case ($urandom_range(4))
      0: return $urandom_range(20) - 10;
      1: return $urandom;
      2: return {{16{1'($urandom_range(1))}}, 16'($urandom)};
      3: return ($urandom_range(1) ? 32'h8000_0000 : 32'h7fff_ffff);
      default: return $urandom_range(1000) - 500;
    endcase
  endfunction

  function automatic logic [30:0] rand_den();
    case ($urandom_range(5))
      0: return 31'($urandom_range(12) + 1);
      1: return 31'($urandom) | 31'd1;
      2: return 31'h7fff_ffff;
      3: return 31'd0;
      default: return 31'($urandom_range(2000) + 1);
    endcase
  endfunction

  function automatic rau_pkg::rau_in_t rand_request();
    rau_pkg::rau_in_t r;
    r.mode  = $urandom_range(9) == 0 ? 3'($urandom_range(7, 5)) : 3'($urandom_range(4));
    r.a_num = rand_num();
    r.a_den = rand_den();
    r.b_num = $urandom_range(15) == 0 ? 32'sd0 : rand_num();
    r.b_den = rand_den();
    // Equal values now and then, so the equal flag gets exercised.
    if ($urandom_range(7) == 0) begin
      r.b_num = r.a_num;
      r.b_den = r.a_den;
    end
    return r;
  endfunction

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (result_queue.size() != 0) @(negedge clk);
  endtask

  task automatic test_directed();
    logic [2:0] m;
    for (int i = 0; i < 5; i++) begin
      m = 3'(i);
      send_request('{m, 32'sh7fff_ffff, 31'h7fff_ffff, 32'sh8000_0000, 31'd1});
    end
    send_request('{rau_pkg::MODE_ADD, 32'sd0, 31'd5, 32'sd0, 31'd7});
    send_request('{rau_pkg::MODE_SUB, 32'sd3, 31'd4, 32'sd6, 31'd8});
    send_request('{rau_pkg::MODE_MUL, -32'sd6, 31'd4, 32'sd2, 31'd3});
    send_request('{rau_pkg::MODE_DIV, 32'sd1, 31'd2, -32'sd3, 31'd5});
    send_request('{rau_pkg::MODE_DIV, 32'sd1, 31'd2, 32'sd0, 31'd5});
    send_request('{rau_pkg::MODE_ADD, 32'sd1, 31'd0, 32'sd1, 31'd1});
    send_request('{MODE_CMP, 32'sd1, 31'd3, 32'sd1, 31'd0});
    send_request('{MODE_CMP, -32'sd1, 31'd3, 32'sd1, 31'd3});
    send_request('{3'd7, 32'sd2, 31'd4, 32'sd1, 31'd2});
    send_request('{3'd5, 32'sh8000_0000, 31'd1, 32'sh8000_0000, 31'd1});
    send_request('{rau_pkg::MODE_DIV, 32'sh8000_0000, 31'h7fff_ffff,
                   32'sh8000_0000, 31'h7fff_ffff});
    send_request('{rau_pkg::MODE_MUL, 32'sh8000_0000, 31'd1, 32'sh8000_0000, 31'd1});
    send_request('{rau_pkg::MODE_SUB, -32'sd1, 31'h5555_5555, 32'sd1, 31'h2aaa_aaaa});
  endtask

  task automatic test_random(int count, int idle_pct, int stall_pct);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    for (int i = 0; i < count; i++) send_request(rand_request());
  endtask

  initial begin
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    out_stall = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    test_directed();
    test_random(280, 19, 58);
    // Let the block run empty before the next phase.
    wait_drained();
    test_random(280, 58, 19);
    test_random(290, 0, 0);
    wait_drained();
    repeat (300) @(posedge clk);
    if (mismatch_count == 0 && result_queue.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule
